// ----- rtl/core/pres80_pkg.sv -----
// ----------------------------------------------------------------------------
// pres80_pkg
// Shared types, constants and round functions for the PRESENT-80 encryptor.
// ----------------------------------------------------------------------------
package pres80_pkg;

    localparam int ROUNDS    = 31;
    localparam int BLOCK_W   = 64;
    localparam int KEY_W     = 80;
    localparam int KEY_LO_W  = 16;
    localparam int RND_W     = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER = 2'd1;

    localparam logic [3:0] SBOX [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };

    typedef struct packed {
        logic [BLOCK_W-1:0] state;
        logic [KEY_W-1:0]   key;
    } t_pipe;

    function automatic logic [BLOCK_W-1:0] sbox_layer(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] r;
        r = '0;
        for (int n = 0; n < BLOCK_W / 4; n++) begin
            r[4*n +: 4] = SBOX[s[4*n +: 4]];
        end
        return r;
    endfunction

    function automatic logic [BLOCK_W-1:0] perm_layer(input logic [BLOCK_W-1:0] s);
        logic [BLOCK_W-1:0] r;
        r = '0;
        for (int b = 0; b < BLOCK_W - 1; b++) begin
            r[(16 * b) % (BLOCK_W - 1)] = s[b];
        end
        r[BLOCK_W-1] = s[BLOCK_W-1];
        return r;
    endfunction

    // rotate left 61, S-box on top nibble, round counter into bits 19..15
    function automatic logic [KEY_W-1:0] key_update(input logic [KEY_W-1:0] k,
                                                    input logic [RND_W-1:0] rnd);
        logic [KEY_W-1:0] r;
        r = {k[18:0], k[KEY_W-1:19]};
        r[KEY_W-1 -: 4] = SBOX[r[KEY_W-1 -: 4]];
        r[19:15] = r[19:15] ^ rnd;
        return r;
    endfunction

    function automatic logic [BLOCK_W-1:0] round_key(input logic [KEY_W-1:0] k);
        return k[KEY_W-1 -: BLOCK_W];
    endfunction

endpackage

// ----- rtl/core/pres80_cfg.sv -----
// ----------------------------------------------------------------------------
// pres80_cfg
// Key register file: upper 64 and lower 16 bits of the 80-bit key.
// ----------------------------------------------------------------------------
module pres80_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pres80_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pres80_pkg::BLOCK_W-1:0]      i_cfg_data,
    output logic [pres80_pkg::KEY_W-1:0]        o_key
);

    logic [pres80_pkg::BLOCK_W-1:0]  r_key_upper;
    logic [pres80_pkg::KEY_LO_W-1:0] r_key_lower;

    assign o_cfg_ready = 1'b1;
    assign o_key       = {r_key_upper, r_key_lower};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_upper <= '0;
            r_key_lower <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pres80_pkg::REG_KEY_UPPER: begin
                    r_key_upper <= i_cfg_data;
                end
                pres80_pkg::REG_KEY_LOWER: begin
                    r_key_lower <= i_cfg_data[pres80_pkg::KEY_LO_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/pres80_round.sv -----
// ----------------------------------------------------------------------------
// pres80_round
// One registered cipher round: key add, S-box layer, bit permutation and
// key schedule step, with a valid/ready pipeline slot.
// ----------------------------------------------------------------------------
module pres80_round (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [pres80_pkg::RND_W-1:0]      i_round,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  pres80_pkg::t_pipe                 i_data,
    output logic                              o_valid,
    input  logic                              i_ready,
    output pres80_pkg::t_pipe                 o_data
);

    logic               r_valid;
    pres80_pkg::t_pipe  r_data;
    pres80_pkg::t_pipe  n_data;

    always_comb begin
        n_data.state = pres80_pkg::perm_layer(pres80_pkg::sbox_layer(
                           i_data.state ^ pres80_pkg::round_key(i_data.key)));
        n_data.key   = pres80_pkg::key_update(i_data.key, i_round);
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ----- rtl/core/present80_block_encrypt_top.sv -----
// ----------------------------------------------------------------------------
// present80_block_encrypt_top
// PRESENT-80 block encryption, one round per pipeline stage.
//
//   channel   dir   signals                         payload
//   s_axis    in    tvalid/tready/tdata[63:0]       plaintext
//   m_axis    out   tvalid/tready/tdata[63:0]       ciphertext
//   cfg       in    valid/ready/index[1:0]/data     key_upper, key_lower
//
// One request accepted per cycle while the output is not stalled; 33 register
// stages (input register, 31 round stages, output register with the final
// key add).
// The input register and each round stage hold their own copy of the key schedule.
// Reset clears all stage valid bits and both key registers.
// A stalled output only blocks stages that are full; bubbles are squeezed out.
// ----------------------------------------------------------------------------
module present80_block_encrypt_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [pres80_pkg::BLOCK_W-1:0]      i_s_axis_tdata,  // [63:0] plaintext
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [pres80_pkg::BLOCK_W-1:0]      o_m_axis_tdata,  // [63:0] ciphertext
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pres80_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pres80_pkg::BLOCK_W-1:0]      i_cfg_data
);

    localparam int N = pres80_pkg::ROUNDS;

    logic [pres80_pkg::KEY_W-1:0]   key;

    logic                           r_in_valid;
    pres80_pkg::t_pipe              r_in_data;
    logic                           in_ready;

    logic                           stg_valid [N+1];
    logic                           stg_ready [N+1];
    pres80_pkg::t_pipe              stg_data  [N+1];

    logic                           r_out_valid;
    logic [pres80_pkg::BLOCK_W-1:0] r_out_data;
    logic                           out_ready;

    pres80_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_key       (key)
    );

    // input register
    assign in_ready        = !r_in_valid || stg_ready[0];
    assign o_s_axis_tready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_s_axis_tvalid) begin
            r_in_data.state <= i_s_axis_tdata;
            r_in_data.key   <= key;
        end
    end

    assign stg_valid[0] = r_in_valid;
    assign stg_data[0]  = r_in_data;

    // round stages
    for (genvar g = 0; g < N; g++) begin : g_round
        pres80_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_round (pres80_pkg::RND_W'(g + 1)),
            .i_valid (stg_valid[g]),
            .o_ready (stg_ready[g]),
            .i_data  (stg_data[g]),
            .o_valid (stg_valid[g+1]),
            .i_ready (stg_ready[g+1]),
            .o_data  (stg_data[g+1])
        );
    end

    // output register with final key add
    assign out_ready    = !r_out_valid || i_m_axis_tready;
    assign stg_ready[N] = out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= stg_valid[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && stg_valid[N]) begin
            r_out_data <= stg_data[N].state ^ pres80_pkg::round_key(stg_data[N].key);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ----- bench/present80_block_encrypt_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// present80_block_encrypt_top_tb
// Checks PRESENT-80 encryption of streamed plaintext blocks against an
// in-bench cipher model. The keys are programmed over the config channel while
// the pipeline is empty. Directed blocks run under the reset key and the
// all-ones key, followed by random blocks under random keys with several
// sender and receiver idle mixes. One long receiver hold-off backs up the
// pipeline so that the input side stalls.
// ----------------------------------------------------------------------------
module present80_block_encrypt_top_tb;

    localparam int LATENCY      = 33;
    localparam int SETTLE       = 2 * LATENCY;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_BLOCKS = 400;
    localparam int FILL_BLOCKS  = 150;

    // indexes past the register list, writes there are dropped
    localparam logic [pres80_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [pres80_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam bit [3:0] NIBBLE_SUB [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };

    class cipher_scoreboard;
        bit [63:0] key_hi;
        bit [15:0] key_lo;
        bit [63:0] expected_ct [$];
        int        failures;

        function void set_register(bit [pres80_pkg::CFG_IDX_W-1:0] idx, bit [63:0] value);
            case (idx)
                pres80_pkg::REG_KEY_UPPER: key_hi = value;
                pres80_pkg::REG_KEY_LOWER: key_lo = value[15:0];
                default: ;
            endcase
        endfunction

        function bit [63:0] encipher(bit [63:0] pt);
            bit [79:0] k;
            bit [63:0] s;
            bit [63:0] t;
            k = {key_hi, key_lo};
            s = pt;
            for (int r = 1; r <= pres80_pkg::ROUNDS; r++) begin
                s = s ^ k[79:16];
                for (int n = 0; n < 16; n++) begin
                    t[4*n +: 4] = NIBBLE_SUB[s[4*n +: 4]];
                end
                for (int b = 0; b < 63; b++) begin
                    s[(16 * b) % 63] = t[b];
                end
                s[63] = t[63];
                k = {k[18:0], k[79:19]};
                k[79:76] = NIBBLE_SUB[k[79:76]];
                k[19:15] = k[19:15] ^ r[4:0];
            end
            return s ^ k[79:16];
        endfunction

        function int pending();
            return expected_ct.size();
        endfunction

        function void note_plaintext(bit [63:0] pt);
            expected_ct.push_back(encipher(pt));
        endfunction

        function void check_ciphertext(logic [63:0] ct);
            bit [63:0] want;
            if (expected_ct.size() == 0) begin
                failures++;
                if (failures <= 10) $display("unexpected ciphertext %h", ct);
                return;
            end
            want = expected_ct.pop_front();
            if (ct !== want) begin
                failures++;
                if (failures <= 10) $display("ciphertext mismatch: expected %h got %h", want, ct);
            end
        endfunction
    endclass

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_s_axis_tvalid = 1'b0;
    logic                                o_s_axis_tready;
    logic [pres80_pkg::BLOCK_W-1:0]      i_s_axis_tdata = '0;    // [63:0] plaintext
    logic                                o_m_axis_tvalid;
    logic                                i_m_axis_tready = 1'b0;
    logic [pres80_pkg::BLOCK_W-1:0]      o_m_axis_tdata;         // [63:0] ciphertext
    logic                                i_cfg_valid = 1'b0;
    logic                                o_cfg_ready;
    logic [pres80_pkg::CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [pres80_pkg::BLOCK_W-1:0]      i_cfg_data = '0;

    cipher_scoreboard sb;
    int               stall_pct = 0;
    logic             hold_off = 1'b0;
    int               cycles = 0;

    present80_block_encrypt_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (hold_off) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // request and result monitor
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (i_s_axis_tvalid && o_s_axis_tready === 1'b1) sb.note_plaintext(i_s_axis_tdata);
            if (o_m_axis_tvalid === 1'b1 && i_m_axis_tready) sb.check_ciphertext(o_m_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [63:0] pick_block();
        case ($urandom_range(19))
            0:       return '0;
            1:       return '1;
            2:       return 64'h1 << $urandom_range(63);
            3:       return ~(64'h1 << $urandom_range(63));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic write_reg(logic [pres80_pkg::CFG_IDX_W-1:0] idx, logic [63:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sb.set_register(idx, value);
    endtask

    task automatic program_key(logic [63:0] upper, logic [63:0] lower);
        write_reg(pres80_pkg::REG_KEY_UPPER, upper);
        write_reg(pres80_pkg::REG_KEY_LOWER, lower);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_block(logic [63:0] pt, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= pt;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
    endtask

    task automatic send_random(int count, int idle_pct);
        repeat (count) send_block(pick_block(), idle_pct);
        i_s_axis_tvalid <= 1'b0;
    endtask

    task automatic hold_receiver(int n);
        hold_off <= 1'b1;
        repeat (n) @(posedge i_clk);
        hold_off <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    logic [63:0] directed [12] = '{
        64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
        64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
        64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
        64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000,
        64'h0000_0000_0000_00FF, 64'hFF00_0000_0000_0000,
        64'h7FFF_FFFF_FFFF_FFFE, 64'h0F0F_0F0F_0F0F_0F0F
    };
    int send_idle [4] = '{0, 79, 0, 36};
    int recv_stall [4] = '{0, 0, 79, 36};

    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset key is all zeros
        foreach (directed[i]) send_block(directed[i], 0);
        i_s_axis_tvalid <= 1'b0;
        drain();

        write_reg(REG_SPARE_A, {$urandom, $urandom});
        write_reg(REG_SPARE_B, {$urandom, $urandom});
        program_key('1, '1);
        foreach (directed[i]) send_block(directed[i], 0);
        i_s_axis_tvalid <= 1'b0;
        drain();

        for (int p = 0; p < 4; p++) begin
            program_key({$urandom, $urandom}, {$urandom, $urandom});
            stall_pct <= recv_stall[p];
            send_random(PHASE_BLOCKS, send_idle[p]);
            drain();
        end

        // back up the pipeline behind a long output stall
        program_key({$urandom, $urandom}, {$urandom, $urandom});
        stall_pct <= 0;
        fork
            hold_receiver(HOLD_CYCLES);
            send_random(FILL_BLOCKS, 0);
        join
        drain();

        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- present80_block_encrypt_top.f -----
rtl/core/pres80_pkg.sv
rtl/core/pres80_cfg.sv
rtl/core/pres80_round.sv
rtl/core/present80_block_encrypt_top.sv
bench/present80_block_encrypt_top_tb.sv
